>>> rtl/core/asss_pkg.sv
package asss_pkg;

   localparam int MaxParamsDefault = 16;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_of_text;
   } req_type;

   typedef struct packed {
      logic [7:0]  text_byte;
      logic        is_bold;
      logic        is_dim;
      logic        is_underline;
      logic        is_strike;
      logic        fg_set;
      logic [23:0] fg_rgb;
      logic        bg_set;
      logic [23:0] bg_rgb;
      logic        span_start;
   } rsp_type;

   typedef struct packed {
      logic        bold;
      logic        dim;
      logic        underline;
      logic        strike;
      logic        fg_set;
      logic [23:0] fg_rgb;
      logic        bg_set;
      logic [23:0] bg_rgb;
   } style_type;

   localparam logic [7:0] ChEsc  = 8'h1B;
   localparam logic [7:0] ChBel  = 8'h07;
   localparam logic [7:0] ChCsi  = 8'h5B;
   localparam logic [7:0] ChOsc  = 8'h5D;
   localparam logic [7:0] ChBsl  = 8'h5C;
   localparam logic [7:0] ChSemi = 8'h3B;
   localparam logic [7:0] ChM    = 8'h6D;
   localparam logic [7:0] ChMinus = 8'h2D;

   function automatic logic [23:0] pal16(input logic [3:0] i);
      case (i)
         4'd0:  pal16 = 24'h000000;
         4'd1:  pal16 = 24'hCD0000;
         4'd2:  pal16 = 24'h00CD00;
         4'd3:  pal16 = 24'hCDCD00;
         4'd4:  pal16 = 24'h0000EE;
         4'd5:  pal16 = 24'hCD00CD;
         4'd6:  pal16 = 24'h00CDCD;
         4'd7:  pal16 = 24'hE5E5E5;
         4'd8:  pal16 = 24'h7F7F7F;
         4'd9:  pal16 = 24'hFF0000;
         4'd10: pal16 = 24'h00FF00;
         4'd11: pal16 = 24'hFFFF00;
         4'd12: pal16 = 24'h5C5CFF;
         4'd13: pal16 = 24'hFF00FF;
         4'd14: pal16 = 24'h00FFFF;
         default: pal16 = 24'hFFFFFF;
      endcase
   endfunction

   function automatic logic [7:0] cube_level(input logic [2:0] i);
      case (i)
         3'd0: cube_level = 8'd0;
         3'd1: cube_level = 8'd95;
         3'd2: cube_level = 8'd135;
         3'd3: cube_level = 8'd175;
         3'd4: cube_level = 8'd215;
         default: cube_level = 8'd255;
      endcase
   endfunction

   // 256-entry palette, computed from the index
   function automatic logic [23:0] palette_rgb(input logic [31:0] idx);
      logic [7:0] v;
      logic [7:0] g;
      logic [7:0] c;
      logic [2:0] q36;
      logic [2:0] q6;
      // negative index counts as 0; grey ramp wraps on the low byte
      v = idx[31] ? 8'd0 : idx[7:0];
      g = 8'd8 + (v - 8'd232) * 8'd10;
      c = v - 8'd16;
      q36 = 3'd0;
      for (int k = 1; k < 6; k++) begin
         if (c >= 8'(36 * k)) q36 = 3'(k);
      end
      c = c - {5'd0, q36} * 8'd36;
      q6 = 3'd0;
      for (int k = 1; k < 6; k++) begin
         if (c >= 8'(6 * k)) q6 = 3'(k);
      end
      c = c - {5'd0, q6} * 8'd6;
      if (!idx[31] && idx[30:8] != 23'd0) begin
         palette_rgb = {g, g, g};
      end else if (v < 8'd16) begin
         palette_rgb = pal16(v[3:0]);
      end else if (v < 8'd232) begin
         palette_rgb = {cube_level(q36), cube_level(q6), cube_level(c[2:0])};
      end else begin
         palette_rgb = {g, g, g};
      end
   endfunction

endpackage

>>> rtl/core/asss_param_ram.sv
module asss_param_ram #(
   parameter int MAX_PARAMS = asss_pkg::MaxParamsDefault,
   localparam int AW = $clog2(MAX_PARAMS)
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [31:0]   wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [31:0]   rd_data
);
   logic [31:0] mem [MAX_PARAMS];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

>>> rtl/core/ansi_sgr_stream_styler.sv
// a plain byte's transfer is registered and shows in the cycle after acceptance
// each byte is finished before the next is taken; an sgr final byte walks the
// parameter memory, a read and an apply per token, then a done and a rest step
// a waiting rsp transfer holds off req until it is taken
// reset: synchronous active high; ground phase, style cleared, span pending
module ansi_sgr_stream_styler #(
   parameter int MAX_PARAMS = asss_pkg::MaxParamsDefault
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  asss_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output asss_pkg::rsp_type rsp_data
);
   localparam int AW = $clog2(MAX_PARAMS);
   localparam int CW = $clog2(MAX_PARAMS + 1);

   typedef enum logic [2:0] {
      PH_GROUND, PH_ESC, PH_CSI, PH_OSC, PH_OSC_ESC
   } phase_type;

   typedef enum logic [2:0] {
      ST_TAKE, ST_REST, ST_RD, ST_APPLY, ST_DONE
   } fsm_type;

   // sgr walk step: what the fetched token means
   typedef enum logic [2:0] {
      W_CODE, W_MODE, W_IDX, W_R, W_G, W_B
   } walk_type;

   phase_type           phase_ff;
   fsm_type             fsm_ff;
   walk_type            walk_ff;
   logic [CW-1:0]       count_ff;
   logic [CW-1:0]       ptr_ff;
   logic [31:0]         tok_ff;
   logic                neg_ff, dig_ff, bad_ff;
   asss_pkg::style_type style_ff, next_ff;
   logic                pend_ff, fg_ff, eot_ff;
   logic [23:0]         rgb_ff;
   logic                rsp_valid_ff;
   asss_pkg::rsp_type   rsp_ff;

   logic                wr_en;
   logic [AW-1:0]       wr_addr;
   logic [31:0]         wr_data;
   logic [31:0]         rd_data;
   logic [31:0]         tok_val;
   logic [7:0]          b;
   logic                take;
   logic                rsp_emit;
   logic [34:0]         t10;

   asss_param_ram #(.MAX_PARAMS(MAX_PARAMS)) u_ram (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(ptr_ff[AW-1:0]), .rd_data(rd_data)
   );

   assign b = req_data.in_byte;
   assign req_stall = (fsm_ff != ST_TAKE) || (rsp_valid_ff && rsp_stall);
   assign take = req_valid && !req_stall;
   assign rsp_emit = take && phase_ff == PH_GROUND && b != asss_pkg::ChEsc;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   always_comb begin
      tok_val = 32'd0;
      if (!bad_ff && dig_ff) begin
         if (neg_ff) tok_val = 32'd0 - tok_ff;
         else if (!tok_ff[31]) tok_val = tok_ff;
      end
   end

   assign t10 = {3'd0, tok_ff} * 35'd10 + {27'd0, b - 8'h30};
   assign wr_en = take && phase_ff == PH_CSI && count_ff < CW'(MAX_PARAMS)
                  && (b == asss_pkg::ChSemi || b == asss_pkg::ChM);
   assign wr_addr = count_ff[AW-1:0];
   assign wr_data = tok_val;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_GROUND;
         fsm_ff <= ST_TAKE;
         count_ff <= '0;
         tok_ff <= '0; neg_ff <= 1'b0; dig_ff <= 1'b0; bad_ff <= 1'b0;
         style_ff <= '0;
         pend_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
         eot_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall && !rsp_emit) rsp_valid_ff <= 1'b0;
         unique case (fsm_ff)
            ST_TAKE: if (take) begin
               fsm_ff <= ST_REST;
               eot_ff <= req_data.end_of_text;
               unique case (phase_ff)
                  PH_GROUND: if (b == asss_pkg::ChEsc) phase_ff <= PH_ESC;
                  else begin
                     rsp_valid_ff <= 1'b1;
                     rsp_ff <= {b, style_ff.bold, style_ff.dim, style_ff.underline,
                                style_ff.strike, style_ff.fg_set, style_ff.fg_rgb,
                                style_ff.bg_set, style_ff.bg_rgb, pend_ff};
                     pend_ff <= 1'b0;
                  end
                  PH_ESC: begin
                     if (b == asss_pkg::ChCsi) begin
                        phase_ff <= PH_CSI;
                        count_ff <= '0;
                        tok_ff <= '0; neg_ff <= 1'b0; dig_ff <= 1'b0; bad_ff <= 1'b0;
                     end else if (b == asss_pkg::ChOsc) phase_ff <= PH_OSC;
                     else phase_ff <= PH_GROUND;
                  end
                  PH_CSI: begin
                     if (b >= 8'h40 && b <= 8'h7E) begin
                        phase_ff <= PH_GROUND;
                        tok_ff <= '0; neg_ff <= 1'b0; dig_ff <= 1'b0; bad_ff <= 1'b0;
                        if (b == asss_pkg::ChM) begin
                           if (count_ff < CW'(MAX_PARAMS)) count_ff <= count_ff + 1'b1;
                           next_ff <= style_ff;
                           ptr_ff <= '0;
                           walk_ff <= W_CODE;
                           fsm_ff <= ST_RD;
                        end else count_ff <= '0;
                     end else if (b == asss_pkg::ChSemi) begin
                        if (count_ff < CW'(MAX_PARAMS)) count_ff <= count_ff + 1'b1;
                        tok_ff <= '0; neg_ff <= 1'b0; dig_ff <= 1'b0; bad_ff <= 1'b0;
                     end else if (b >= 8'h30 && b <= 8'h39) begin
                        dig_ff <= 1'b1;
                        if (tok_ff > 32'd214748364 || t10 > 35'h80000000) bad_ff <= 1'b1;
                        else tok_ff <= t10[31:0];
                     end else if (b == asss_pkg::ChMinus && !dig_ff && !neg_ff) begin
                        neg_ff <= 1'b1;
                     end else bad_ff <= 1'b1;
                  end
                  PH_OSC: begin
                     if (b == asss_pkg::ChBel) phase_ff <= PH_GROUND;
                     else if (b == asss_pkg::ChEsc) phase_ff <= PH_OSC_ESC;
                  end
                  default: begin
                     if (b == asss_pkg::ChBsl || b == asss_pkg::ChBel) phase_ff <= PH_GROUND;
                     else if (b == asss_pkg::ChEsc) phase_ff <= PH_OSC_ESC;
                     else phase_ff <= PH_OSC;
                  end
               endcase
            end
            ST_RD: begin
               if (ptr_ff >= count_ff) fsm_ff <= ST_DONE;
               else fsm_ff <= ST_APPLY;
            end
            ST_APPLY: begin
               fsm_ff <= ST_RD;
               ptr_ff <= ptr_ff + 1'b1;
               case (walk_ff)
                  W_CODE: begin
                     if (rd_data == 32'd0) next_ff <= '0;
                     else if (rd_data == 32'd1) next_ff.bold <= 1'b1;
                     else if (rd_data == 32'd2) next_ff.dim <= 1'b1;
                     else if (rd_data == 32'd4) next_ff.underline <= 1'b1;
                     else if (rd_data == 32'd9) next_ff.strike <= 1'b1;
                     else if (rd_data == 32'd22) begin
                        next_ff.bold <= 1'b0; next_ff.dim <= 1'b0;
                     end else if (rd_data == 32'd24) next_ff.underline <= 1'b0;
                     else if (rd_data == 32'd29) next_ff.strike <= 1'b0;
                     else if (rd_data == 32'd39) begin
                        next_ff.fg_set <= 1'b0; next_ff.fg_rgb <= '0;
                     end else if (rd_data == 32'd49) begin
                        next_ff.bg_set <= 1'b0; next_ff.bg_rgb <= '0;
                     end else if (rd_data >= 32'd30 && rd_data <= 32'd37) begin
                        next_ff.fg_set <= 1'b1;
                        next_ff.fg_rgb <= asss_pkg::pal16(4'(rd_data - 32'd30));
                     end else if (rd_data >= 32'd40 && rd_data <= 32'd47) begin
                        next_ff.bg_set <= 1'b1;
                        next_ff.bg_rgb <= asss_pkg::pal16(4'(rd_data - 32'd40));
                     end else if (rd_data >= 32'd90 && rd_data <= 32'd97) begin
                        next_ff.fg_set <= 1'b1;
                        next_ff.fg_rgb <= asss_pkg::pal16(4'(rd_data - 32'd82));
                     end else if (rd_data >= 32'd100 && rd_data <= 32'd107) begin
                        next_ff.bg_set <= 1'b1;
                        next_ff.bg_rgb <= asss_pkg::pal16(4'(rd_data - 32'd92));
                     end else if ((rd_data == 32'd38 || rd_data == 32'd48)
                                  && ptr_ff + 1'b1 < count_ff) begin
                        fg_ff <= (rd_data == 32'd38);
                        walk_ff <= W_MODE;
                     end
                  end
                  W_MODE: begin
                     walk_ff <= W_CODE;
                     if (rd_data == 32'd5 && ptr_ff + 1'b1 < count_ff) walk_ff <= W_IDX;
                     else if (rd_data == 32'd2 && {1'b0, ptr_ff} + 2'd3 < {1'b0, count_ff})
                        walk_ff <= W_R;
                  end
                  W_IDX: begin
                     walk_ff <= W_CODE;
                     if (fg_ff) begin
                        next_ff.fg_set <= 1'b1;
                        next_ff.fg_rgb <= asss_pkg::palette_rgb(rd_data);
                     end else begin
                        next_ff.bg_set <= 1'b1;
                        next_ff.bg_rgb <= asss_pkg::palette_rgb(rd_data);
                     end
                  end
                  W_R: begin rgb_ff[23:16] <= rd_data[7:0]; walk_ff <= W_G; end
                  W_G: begin rgb_ff[15:8] <= rd_data[7:0]; walk_ff <= W_B; end
                  default: begin
                     walk_ff <= W_CODE;
                     if (fg_ff) begin
                        next_ff.fg_set <= 1'b1;
                        next_ff.fg_rgb <= {rgb_ff[23:8], rd_data[7:0]};
                     end else begin
                        next_ff.bg_set <= 1'b1;
                        next_ff.bg_rgb <= {rgb_ff[23:8], rd_data[7:0]};
                     end
                  end
               endcase
            end
            ST_DONE: begin
               fsm_ff <= ST_REST;
               count_ff <= '0;
               if (next_ff != style_ff) begin
                  style_ff <= next_ff;
                  pend_ff <= 1'b1;
               end
            end
            default: begin
               fsm_ff <= ST_TAKE;
               if (eot_ff) begin
                  phase_ff <= PH_GROUND;
                  count_ff <= '0;
                  tok_ff <= '0; neg_ff <= 1'b0; dig_ff <= 1'b0; bad_ff <= 1'b0;
                  style_ff <= '0;
                  pend_ff <= 1'b1;
               end
            end
         endcase
      end
   end

   a_no_take_busy: assert property (@(posedge clock) disable iff (reset)
      (fsm_ff != ST_TAKE) |-> !take) else $error("transfer taken while busy");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_PARAMS)) else $error("param count overflow");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid) else $error("response dropped");
   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      (fsm_ff == ST_APPLY) |-> (ptr_ff < count_ff)) else $error("walk past count");
endmodule
